// ===== hw/rtl/camera_keyframe_interpolator_defines.svh =====
`ifndef CAMERA_KEYFRAME_INTERPOLATOR_DEFINES_SVH
`define CAMERA_KEYFRAME_INTERPOLATOR_DEFINES_SVH

// implication checked on every clock edge out of reset
`define CKF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain invariant
`define CKF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== hw/rtl/ckf_pkg.sv =====
`timescale 1ns / 1ps

package ckf_pkg;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic CFG_KEYFRAME_COUNT = 1'b0;
    localparam logic CFG_EASE_ENABLE    = 1'b1;

    localparam int FRAME_W     = 24;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [15:0] fov;
        logic signed [15:0] bank;
    } cam_data_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        cam_data_t          data;
    } cam_key_t;

    typedef struct packed {
        logic        op;
        logic [5:0]  slot;
        cam_key_t    key;
        logic [31:0] pos;
    } ckf_cmd_t;

    typedef struct packed {
        logic busy;
        logic emit;
    } ckf_status_t;

endpackage

// ===== hw/rtl/ckf_req_if.sv =====
`timescale 1ns / 1ps

interface ckf_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic        [5:0]  entry_index;
    logic        [23:0] key_frame;
    logic signed [31:0] key_eye_x;
    logic signed [31:0] key_eye_y;
    logic signed [31:0] key_eye_z;
    logic signed [31:0] key_center_x;
    logic signed [31:0] key_center_y;
    logic signed [31:0] key_center_z;
    logic        [15:0] key_fov;
    logic signed [15:0] key_bank;
    logic        [31:0] sample_position;

    modport source (
        output valid, command, entry_index, key_frame, key_eye_x, key_eye_y, key_eye_z,
               key_center_x, key_center_y, key_center_z, key_fov, key_bank,
               sample_position,
        input  ready
    );

    modport sink (
        input  valid, command, entry_index, key_frame, key_eye_x, key_eye_y, key_eye_z,
               key_center_x, key_center_y, key_center_z, key_fov, key_bank,
               sample_position,
        output ready
    );
endinterface

// ===== hw/rtl/ckf_rsp_if.sv =====
`timescale 1ns / 1ps

interface ckf_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_eye_x;
    logic signed [31:0] out_eye_y;
    logic signed [31:0] out_eye_z;
    logic signed [31:0] out_center_x;
    logic signed [31:0] out_center_y;
    logic signed [31:0] out_center_z;
    logic        [15:0] out_fov;
    logic signed [15:0] out_bank;

    modport source (
        output valid, out_eye_x, out_eye_y, out_eye_z, out_center_x, out_center_y,
               out_center_z, out_fov, out_bank,
        input  ready
    );

    modport sink (
        input  valid, out_eye_x, out_eye_y, out_eye_z, out_center_x, out_center_y,
               out_center_z, out_fov, out_bank,
        output ready
    );
endinterface

// ===== hw/rtl/ckf_ram.sv =====
`timescale 1ns / 1ps

module ckf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/ckf_front.sv =====
`timescale 1ns / 1ps

module ckf_front #(
    parameter int MAX_KEYFRAMES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    ckf_req_if.sink            req,
    output ckf_pkg::ckf_cmd_t  push_item,
    output logic               push_valid,
    input  logic               push_ready
);

    logic              st_valid_reg;
    logic              st_valid_next;
    ckf_pkg::ckf_cmd_t st_cmd_reg;
    logic              accept;
    logic              keep;

    assign req.ready = !st_valid_reg || push_ready;
    assign accept    = req.valid && req.ready;

    // loads aimed past the end of the store are dropped here
    assign keep = (req.command == ckf_pkg::CMD_SAMPLE)
               || (32'(req.entry_index) < 32'(MAX_KEYFRAMES));

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
        begin
            st_valid_next = keep;
        end
        else if (push_ready)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_cmd_reg.op                 <= req.command;
            st_cmd_reg.slot               <= req.entry_index;
            st_cmd_reg.key.frame          <= req.key_frame;
            st_cmd_reg.key.data.eye_x     <= req.key_eye_x;
            st_cmd_reg.key.data.eye_y     <= req.key_eye_y;
            st_cmd_reg.key.data.eye_z     <= req.key_eye_z;
            st_cmd_reg.key.data.center_x  <= req.key_center_x;
            st_cmd_reg.key.data.center_y  <= req.key_center_y;
            st_cmd_reg.key.data.center_z  <= req.key_center_z;
            st_cmd_reg.key.data.fov       <= req.key_fov;
            st_cmd_reg.key.data.bank      <= req.key_bank;
            st_cmd_reg.pos                <= req.sample_position;
        end
    end

    assign push_valid = st_valid_reg;
    assign push_item  = st_cmd_reg;

endmodule

// ===== hw/rtl/ckf_queue.sv =====
`timescale 1ns / 1ps

module ckf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  ckf_pkg::ckf_cmd_t  push_item,
    input  logic               push_valid,
    output logic               push_ready,
    output ckf_pkg::ckf_cmd_t  pop_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output logic [1:0]         count
);

    ckf_pkg::ckf_cmd_t entry_reg [ckf_pkg::QUEUE_DEPTH];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != 2'(ckf_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/ckf_back.sv =====
`timescale 1ns / 1ps

module ckf_back #(
    parameter int MAX_KEYFRAMES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ckf_pkg::ckf_cmd_t     q_item,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [6:0]            keyframe_count,
    input  logic                  ease_enable,
    ckf_rsp_if.source             rsp,
    output ckf_pkg::ckf_status_t  status
);

    localparam int IDX_W  = $clog2(MAX_KEYFRAMES);
    localparam int CNT_W  = $clog2(MAX_KEYFRAMES + 1);
    localparam int KW     = (CNT_W > 7) ? CNT_W : 7;
    localparam int DATA_W = $bits(ckf_pkg::cam_data_t);
    localparam int FW     = ckf_pkg::FRAME_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_LAST  = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_CUBE  = 4'd7;
    localparam logic [3:0] S_RDA   = 4'd8;
    localparam logic [3:0] S_RDB   = 4'd9;
    localparam logic [3:0] S_RDC   = 4'd10;
    localparam logic [3:0] S_MUL   = 4'd11;
    localparam logic [3:0] S_ADD   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    localparam logic [2:0] FLD_FOV  = 3'd6;
    localparam logic [2:0] FLD_BANK = 3'd7;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic                out_valid_reg;
    logic                out_free;

    logic [KW-1:0]       kc_ext;
    logic [KW-1:0]       n_cnt;
    logic [IDX_W-1:0]    n_last;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    frame_raddr;
    logic [FW-1:0]       frame_rdata;
    logic [IDX_W-1:0]    data_raddr;
    logic [DATA_W-1:0]   data_rdata;

    logic [31:0]         pos_reg;
    logic [FW-1:0]       first_reg;
    logic [FW-1:0]       prev_reg;
    logic [IDX_W-1:0]    k_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    j_reg;
    logic [FW-1:0]       span_reg;
    logic [FW-1:0]       rem_reg;
    logic [15:0]         dvd_reg;
    logic [15:0]         quo_reg;
    logic [3:0]          cnt_reg;
    logic [15:0]         t_reg;
    logic [31:0]         sq_reg;
    ckf_pkg::cam_data_t  a_reg;
    ckf_pkg::cam_data_t  b_reg;
    logic [2:0]          fld_reg;
    logic signed [32:0]  asel_reg;
    logic signed [49:0]  prod_reg;
    logic [31:0]         res_reg [8];
    logic [31:0]         out_reg [8];

    logic                pos_le_first;
    logic                pos_ge_last;
    logic                scan_hit;
    logic [31:0]         off_val;
    logic [FW:0]         trial;
    logic                trial_ge;
    logic [17:0]         ease_factor;
    logic [49:0]         cube;
    logic signed [32:0]  sel_a;
    logic signed [32:0]  sel_d;
    logic [15:0]         bank_d;
    logic signed [34:0]  lin_sum;
    logic signed [49:0]  bank_s;
    logic signed [33:0]  bank_q;
    logic [31:0]         add_val;

    // keyframe count of zero acts as one, large counts stop at the store size
    assign kc_ext = KW'(keyframe_count);
    always_comb
    begin
        if (kc_ext == '0)
        begin
            n_cnt = KW'(1);
        end
        else if (kc_ext > KW'(MAX_KEYFRAMES))
        begin
            n_cnt = KW'(MAX_KEYFRAMES);
        end
        else
        begin
            n_cnt = kc_ext;
        end
    end
    assign n_last = IDX_W'(n_cnt - KW'(1));

    assign q_ready   = (state_reg == S_IDLE);
    assign ram_we    = q_ready && q_valid && (q_item.op == ckf_pkg::CMD_LOAD);
    assign ram_waddr = IDX_W'(q_item.slot);
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        case (state_reg)
            S_LAST:  frame_raddr = n_last;
            S_CHK:   frame_raddr = IDX_W'(1);
            S_SCAN:  frame_raddr = k_reg + IDX_W'(1);
            default: frame_raddr = '0;
        endcase
    end
    assign data_raddr = (state_reg == S_RDB) ? j_reg : i_reg;

    ckf_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_KEYFRAMES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_item.key.frame),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    ckf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_KEYFRAMES)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_item.key.data),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    assign pos_le_first = (pos_reg <= {first_reg, 8'h00});
    assign pos_ge_last  = (pos_reg >= {frame_rdata, 8'h00});
    assign scan_hit     = (pos_reg < {frame_rdata, 8'h00}) || (k_reg == n_last);
    assign off_val      = pos_reg - {prev_reg, 8'h00};

    // restoring divider, one quotient bit a cycle
    assign trial    = {rem_reg, dvd_reg[15]};
    assign trial_ge = (trial >= {1'b0, span_reg});

    assign ease_factor = 18'd196608 - {1'b0, t_reg, 1'b0};
    assign cube        = sq_reg * ease_factor;

    assign bank_d = b_reg.bank - a_reg.bank;

    always_comb
    begin
        case (fld_reg)
            3'd0:
            begin
                sel_a = 33'(a_reg.eye_x);
                sel_d = 33'(b_reg.eye_x) - 33'(a_reg.eye_x);
            end
            3'd1:
            begin
                sel_a = 33'(a_reg.eye_y);
                sel_d = 33'(b_reg.eye_y) - 33'(a_reg.eye_y);
            end
            3'd2:
            begin
                sel_a = 33'(a_reg.eye_z);
                sel_d = 33'(b_reg.eye_z) - 33'(a_reg.eye_z);
            end
            3'd3:
            begin
                sel_a = 33'(a_reg.center_x);
                sel_d = 33'(b_reg.center_x) - 33'(a_reg.center_x);
            end
            3'd4:
            begin
                sel_a = 33'(a_reg.center_y);
                sel_d = 33'(b_reg.center_y) - 33'(a_reg.center_y);
            end
            3'd5:
            begin
                sel_a = 33'(a_reg.center_z);
                sel_d = 33'(b_reg.center_z) - 33'(a_reg.center_z);
            end
            FLD_FOV:
            begin
                sel_a = $signed({17'd0, a_reg.fov});
                sel_d = $signed({17'd0, b_reg.fov}) - $signed({17'd0, a_reg.fov});
            end
            default:
            begin
                sel_a = 33'(a_reg.bank);
                sel_d = 33'($signed(bank_d));
            end
        endcase
    end

    // a plus floored blend term, then clamp to the field range
    assign lin_sum = 35'(asel_reg) + 35'($signed(prod_reg[49:16]));
    // bank rounds toward zero
    assign bank_s  = $signed({asel_reg[32], asel_reg, 16'h0000}) + prod_reg;
    assign bank_q  = $signed(bank_s[49:16])
                   + 34'((bank_s[49] && (bank_s[15:0] != 16'h0000)) ? 1 : 0);

    always_comb
    begin
        if (fld_reg == FLD_BANK)
        begin
            add_val = {16'h0000, bank_q[15:0]};
        end
        else if (fld_reg == FLD_FOV)
        begin
            if (lin_sum < 35'sd0)
            begin
                add_val = 32'd0;
            end
            else if (lin_sum > 35'sd65535)
            begin
                add_val = 32'd65535;
            end
            else
            begin
                add_val = {16'h0000, lin_sum[15:0]};
            end
        end
        else if (lin_sum < -35'sd2147483648)
        begin
            add_val = 32'h8000_0000;
        end
        else if (lin_sum > 35'sd2147483647)
        begin
            add_val = 32'h7fff_ffff;
        end
        else
        begin
            add_val = lin_sum[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && (q_item.op == ckf_pkg::CMD_SAMPLE))
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST: state_next = S_LAST;
            S_LAST:  state_next = S_CHK;
            S_CHK:
            begin
                if ((n_last == '0) || pos_le_first || pos_ge_last)
                begin
                    state_next = S_RDA;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 4'd15)
                begin
                    state_next = ease_enable ? S_SQ : S_RDA;
                end
            end
            S_SQ:   state_next = S_CUBE;
            S_CUBE: state_next = S_RDA;
            S_RDA:  state_next = S_RDB;
            S_RDB:  state_next = S_RDC;
            S_RDC:  state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:
            begin
                state_next = (fld_reg == FLD_BANK) ? S_OUT : S_MUL;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                pos_reg <= q_item.pos;
            end
            S_LAST:
            begin
                first_reg <= frame_rdata;
            end
            S_CHK:
            begin
                t_reg    <= 16'd0;
                k_reg    <= IDX_W'(1);
                prev_reg <= first_reg;
                if ((n_last == '0) || pos_le_first)
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
                else
                begin
                    i_reg <= n_last;
                    j_reg <= n_last;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    i_reg    <= k_reg - IDX_W'(1);
                    j_reg    <= k_reg;
                    span_reg <= frame_rdata - prev_reg;
                    rem_reg  <= off_val[31:8];
                    dvd_reg  <= {off_val[7:0], 8'h00};
                    cnt_reg  <= 4'd0;
                end
                else
                begin
                    prev_reg <= frame_rdata;
                    k_reg    <= k_reg + IDX_W'(1);
                end
            end
            S_DIV:
            begin
                rem_reg <= trial_ge ? FW'(trial - {1'b0, span_reg}) : trial[FW-1:0];
                dvd_reg <= {dvd_reg[14:0], 1'b0};
                quo_reg <= {quo_reg[14:0], trial_ge};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    t_reg <= {quo_reg[14:0], trial_ge};
                end
            end
            S_SQ:
            begin
                sq_reg <= t_reg * t_reg;
            end
            S_CUBE:
            begin
                t_reg <= cube[47:32];
            end
            S_RDB:
            begin
                a_reg <= data_rdata;
            end
            S_RDC:
            begin
                b_reg   <= data_rdata;
                fld_reg <= 3'd0;
            end
            S_MUL:
            begin
                asel_reg <= sel_a;
                prod_reg <= sel_d * $signed({1'b0, t_reg});
            end
            S_ADD:
            begin
                res_reg[fld_reg] <= add_val;
                fld_reg          <= fld_reg + 3'd1;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_eye_x    = out_reg[0];
    assign rsp.out_eye_y    = out_reg[1];
    assign rsp.out_eye_z    = out_reg[2];
    assign rsp.out_center_x = out_reg[3];
    assign rsp.out_center_y = out_reg[4];
    assign rsp.out_center_z = out_reg[5];
    assign rsp.out_fov      = out_reg[6][15:0];
    assign rsp.out_bank     = out_reg[7][15:0];

    assign status.busy = (state_reg != S_IDLE);
    assign status.emit = (state_reg == S_OUT) && out_free;

endmodule

// ===== hw/rtl/camera_keyframe_interpolator.sv =====
// load transaction: front register, queue, then store; one per cycle while no sample is in work
// sample transaction: result set by the linear scan, restoring divider, easing when enabled
// and 8-field blend multiplier; a clamped position skips scan, divider and easing
// samples are worked one at a time; the input queue keeps accepting meanwhile until full
// reset: keyframe_count = 1, ease_enable = 1, all handshakes idle;
// the keyframe store is not cleared and reads undefined until loaded
`timescale 1ns / 1ps
`include "camera_keyframe_interpolator_defines.svh"

module camera_keyframe_interpolator #(
    parameter int MAX_KEYFRAMES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    ckf_req_if.sink     req,
    ckf_rsp_if.source   rsp,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    logic [6:0]            kc_reg;
    logic                  ease_reg;
    ckf_pkg::ckf_cmd_t     push_item;
    logic                  push_valid;
    logic                  push_ready;
    ckf_pkg::ckf_cmd_t     pop_item;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [1:0]            q_count;
    logic                  q_full;
    ckf_pkg::ckf_status_t  back_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg   <= 7'd1;
            ease_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ckf_pkg::CFG_KEYFRAME_COUNT: kc_reg   <= cfg_data;
                ckf_pkg::CFG_EASE_ENABLE:    ease_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    ckf_front #(
        .MAX_KEYFRAMES (MAX_KEYFRAMES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    ckf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .count      (q_count)
    );

    ckf_back #(
        .MAX_KEYFRAMES (MAX_KEYFRAMES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_item         (pop_item),
        .q_valid        (pop_valid),
        .q_ready        (pop_ready),
        .keyframe_count (kc_reg),
        .ease_enable    (ease_reg),
        .rsp            (rsp),
        .status         (back_status)
    );

    assign q_full = (q_count == 2'(ckf_pkg::QUEUE_DEPTH));

    `CKF_ASSERT_ALWAYS(a_queue_bound, q_count <= 2'(ckf_pkg::QUEUE_DEPTH), "queue overfilled")
    `CKF_ASSERT_IMP(a_rsp_from_back, $rose(rsp.valid), $past(back_status.emit), "stray result")
    `CKF_ASSERT_IMP(a_full_busy, q_full && !pop_ready, back_status.busy, "queue full while back idle")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS      = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 120;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [6:0] cfg_data;

    ckf_req_if req_ch ();
    ckf_rsp_if rsp_ch ();

    camera_keyframe_interpolator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ckf_pkg::ckf_cmd_t  pending_cmds[$];
    ckf_pkg::cam_data_t expected_cams[$];

    // predictor copy of the keyframe store and registers
    logic [23:0]        pred_frame[SLOTS];
    ckf_pkg::cam_data_t pred_key[SLOTS];
    logic [6:0]         pred_count;
    logic               pred_ease;

    // generator view of the store, used to keep samples on loaded slots
    logic [23:0] gen_frame[SLOTS];
    bit          gen_loaded[SLOTS];
    int          gen_count;

    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint blend(longint a, longint b, longint t, longint lo, longint hi);
        longint r;
        r = a + (((b - a) * t) >>> 16);
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    function automatic ckf_pkg::cam_data_t blend_cam(int i, int j, longint t);
        ckf_pkg::cam_data_t  c;
        ckf_pkg::cam_data_t  ka;
        ckf_pkg::cam_data_t  kb;
        logic signed [15:0]  dbank;
        longint              s;
        longint              q;
        longint              lo;
        longint              hi;
        ka = pred_key[i];
        kb = pred_key[j];
        lo = -(64'sd1 <<< 31);
        hi = (64'sd1 <<< 31) - 1;
        c.eye_x    = 32'(blend($signed(ka.eye_x), $signed(kb.eye_x), t, lo, hi));
        c.eye_y    = 32'(blend($signed(ka.eye_y), $signed(kb.eye_y), t, lo, hi));
        c.eye_z    = 32'(blend($signed(ka.eye_z), $signed(kb.eye_z), t, lo, hi));
        c.center_x = 32'(blend($signed(ka.center_x), $signed(kb.center_x), t, lo, hi));
        c.center_y = 32'(blend($signed(ka.center_y), $signed(kb.center_y), t, lo, hi));
        c.center_z = 32'(blend($signed(ka.center_z), $signed(kb.center_z), t, lo, hi));
        c.fov      = 16'(blend(longint'(ka.fov), longint'(kb.fov), t, 0, 65535));
        // bank follows the shortest wrapped difference, truncated toward zero
        dbank  = kb.bank - ka.bank;
        s      = longint'($signed(ka.bank)) * 65536 + longint'(dbank) * t;
        q      = s / 65536;
        c.bank = q[15:0];
        return c;
    endfunction

    function automatic ckf_pkg::cam_data_t sample_camera(logic [31:0] pos);
        int          n;
        int          nxt;
        logic [31:0] first_pos;
        logic [31:0] last_pos;
        longint      span;
        longint      off;
        longint      t;
        n = pred_count;
        if (n == 0) n = 1;
        if (n > SLOTS) n = SLOTS;
        first_pos = {pred_frame[0], 8'h00};
        last_pos  = {pred_frame[n-1], 8'h00};
        if (n == 1 || pos <= first_pos) return blend_cam(0, 0, 0);
        if (pos >= last_pos) return blend_cam(n - 1, n - 1, 0);
        nxt = n - 1;
        for (int k = 1; k < n; k++)
        begin
            if (pos < {pred_frame[k], 8'h00})
            begin
                nxt = k;
                break;
            end
        end
        span = longint'(pred_frame[nxt]) - longint'(pred_frame[nxt-1]);
        off  = longint'(pos) - longint'({pred_frame[nxt-1], 8'h00});
        if (span <= 0) t = 65535;
        else
        begin
            t = (off << 8) / span;
            if (t > 65535) t = 65535;
        end
        if (pred_ease) t = (t * t * (3 * 65536 - 2 * t)) >> 32;
        return blend_cam(nxt - 1, nxt, t);
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 6))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // true when every slot of a track of n keys has been loaded
    function automatic bit track_loaded(int n);
        for (int s = 0; s < n; s++)
        begin
            if (!gen_loaded[s]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic push_load(int slot, logic [23:0] frame);
        ckf_pkg::ckf_cmd_t c;
        c.op            = ckf_pkg::CMD_LOAD;
        c.slot          = slot[5:0];
        c.key.frame     = frame;
        c.key.data.eye_x    = pick_coord();
        c.key.data.eye_y    = pick_coord();
        c.key.data.eye_z    = pick_coord();
        c.key.data.center_x = pick_coord();
        c.key.data.center_y = pick_coord();
        c.key.data.center_z = pick_coord();
        c.key.data.fov  = 16'($urandom);
        c.key.data.bank = 16'($urandom);
        c.pos           = $urandom;
        pending_cmds = {pending_cmds, c};
        gen_frame[slot]  = frame;
        gen_loaded[slot] = 1'b1;
    endtask

    task automatic push_sample(logic [31:0] pos);
        ckf_pkg::ckf_cmd_t c;
        c                   = '0;
        c.op                = ckf_pkg::CMD_SAMPLE;
        c.slot              = 6'($urandom);
        c.key.frame         = 24'($urandom);
        c.key.data.eye_x    = $urandom;
        c.key.data.center_z = $urandom;
        c.key.data.bank     = 16'($urandom);
        c.pos               = pos;
        pending_cmds = {pending_cmds, c};
    endtask

    // position around the loaded track, with some outside it
    function automatic logic [31:0] pick_position();
        int          n;
        logic [31:0] lo;
        logic [31:0] hi;
        n  = (gen_count == 0) ? 1 : (gen_count > SLOTS ? SLOTS : gen_count);
        lo = {gen_frame[0], 8'h00};
        hi = {gen_frame[n-1], 8'h00};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return lo;
            2: return hi;
            3: return {gen_frame[$urandom_range(0, n - 1)], 8'h00};
            default:
            begin
                if (hi > lo) return lo + ($urandom % (hi - lo + 1));
                return lo + $urandom_range(0, 512) - 256;
            end
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || req_ch.valid || expected_cams.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == ckf_pkg::CFG_KEYFRAME_COUNT) gen_count = value;
    endtask

    // driver with bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left     <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                ckf_pkg::ckf_cmd_t c;
                c = pending_cmds.pop_front();
                req_ch.valid           <= 1'b1;
                req_ch.command         <= c.op;
                req_ch.entry_index     <= c.slot;
                req_ch.key_frame       <= c.key.frame;
                req_ch.key_eye_x       <= c.key.data.eye_x;
                req_ch.key_eye_y       <= c.key.data.eye_y;
                req_ch.key_eye_z       <= c.key.data.eye_z;
                req_ch.key_center_x    <= c.key.data.center_x;
                req_ch.key_center_y    <= c.key.data.center_y;
                req_ch.key_center_z    <= c.key.data.center_z;
                req_ch.key_fov         <= c.key.data.fov;
                req_ch.key_bank        <= c.key.data.bank;
                req_ch.sample_position <= c.pos;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // receiver stall pattern: stretches of full speed, random stalls and long holds
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_mode   <= 0;
            stall_left   <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(20, 300);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= ($urandom_range(0, 40) == 0);
            endcase
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.command == ckf_pkg::CMD_LOAD)
                begin
                    pred_frame[req_ch.entry_index] = req_ch.key_frame;
                    pred_key[req_ch.entry_index]   = '{req_ch.key_eye_x, req_ch.key_eye_y,
                        req_ch.key_eye_z, req_ch.key_center_x, req_ch.key_center_y,
                        req_ch.key_center_z, req_ch.key_fov, req_ch.key_bank};
                end
                else
                    expected_cams = {expected_cams, sample_camera(req_ch.sample_position)};
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                ckf_pkg::cam_data_t got;
                ckf_pkg::cam_data_t want;
                got = '{rsp_ch.out_eye_x, rsp_ch.out_eye_y, rsp_ch.out_eye_z,
                        rsp_ch.out_center_x, rsp_ch.out_center_y, rsp_ch.out_center_z,
                        rsp_ch.out_fov, rsp_ch.out_bank};
                if (expected_cams.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transaction: %p", got);
                end
                else
                begin
                    want = expected_cams.pop_front();
                    if (got.eye_x !== want.eye_x || got.eye_y !== want.eye_y ||
                        got.eye_z !== want.eye_z || got.center_x !== want.center_x ||
                        got.center_y !== want.center_y || got.center_z !== want.center_z ||
                        got.fov !== want.fov || got.bank !== want.bank)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          generated;
        int          n;
        int          counts[6];
        logic [23:0] f;
        counts = '{0, 1, 2, 5, 64, 127};
        mismatches   = 0;
        idle_cycles  = 0;
        gen_count    = 1;
        pred_count   = 7'd1;
        pred_ease    = 1'b1;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = ckf_pkg::CFG_KEYFRAME_COUNT;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.command = ckf_pkg::CMD_LOAD;
        req_ch.entry_index = '0;
        req_ch.key_frame = '0;
        req_ch.key_eye_x = '0;
        req_ch.key_eye_y = '0;
        req_ch.key_eye_z = '0;
        req_ch.key_center_x = '0;
        req_ch.key_center_y = '0;
        req_ch.key_center_z = '0;
        req_ch.key_fov = '0;
        req_ch.key_bank = '0;
        req_ch.sample_position = '0;
        rsp_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single keyframe at reset settings
        push_load(0, 24'hff_ffff);
        push_sample(32'h0);
        push_sample(32'hffff_ffff);
        wait_idle();

        // four keys, linear blend, ends and exact keys
        write_reg(ckf_pkg::CFG_KEYFRAME_COUNT, 7'd4);
        pred_count = 7'd4;
        write_reg(ckf_pkg::CFG_EASE_ENABLE, 7'd0);
        pred_ease = 1'b0;
        push_load(0, 24'd10);
        push_load(1, 24'd20);
        push_load(2, 24'd21);
        push_load(3, 24'hff_fff0);
        push_sample(32'd0);
        push_sample(32'd10 << 8);
        push_sample((32'd15 << 8) + 8'h80);
        push_sample(32'd20 << 8);
        push_sample((32'd20 << 8) + 8'hff);
        push_sample((32'd21 << 8) + 1);
        push_sample(32'hffff_f000 - 1);
        push_sample(32'hffff_ffff);
        // keys out of order: span from the scan stays positive
        push_load(2, 24'd5);
        push_sample((32'd20 << 8) + 8'h40);
        push_sample((32'd30 << 8));
        wait_idle();
        write_reg(ckf_pkg::CFG_EASE_ENABLE, 7'd1);
        pred_ease = 1'b1;
        push_sample((32'd10 << 8) + 8'h40);
        push_sample(32'h7fff_ffff);
        wait_idle();

        generated = 23;
        while (generated < 650)
        begin
            n = counts[$urandom_range(0, 5)];
            write_reg(ckf_pkg::CFG_KEYFRAME_COUNT, n[6:0]);
            pred_count = n[6:0];
            write_reg(ckf_pkg::CFG_EASE_ENABLE, 7'($urandom_range(0, 1)));
            pred_ease = cfg_data[0];
            if (n == 0) n = 1;
            if (n > SLOTS) n = SLOTS;
            // well-formed ascending track, short steps mostly
            if ($urandom_range(0, 4) != 0 || !track_loaded(n))
            begin
                f = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 24'hf0_0000))
                                                : 24'($urandom_range(0, 200));
                for (int s = 0; s < n; s++)
                begin
                    push_load(s, f);
                    generated++;
                    f = f + (($urandom_range(0, 7) == 0) ? 24'($urandom_range(1, 4000))
                                                         : 24'($urandom_range(1, 20)));
                    if (f < gen_frame[s]) f = 24'hff_ffff;
                end
            end
            for (int k = 0; k < 50; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_load($urandom_range(0, SLOTS - 1), 24'($urandom));
                else
                    push_sample(pick_position());
                generated++;
            end
            wait_idle();
        end

        wait_idle();
        mismatches += expected_cams.size();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
